@@ design/itoa_pkg.sv @@
// Package for the signed integer to decimal ASCII unit.
// Holds controller states, the command and status words and the character constants.
// No dependencies.
package itoa_pkg;

  localparam int VALUE_W = 32;
  localparam int CHAR_W  = 8;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_LOCATE,
    ST_SIGN,
    ST_DIGITS
  } itoa_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture a new word and form its magnitude
    logic step;     // run four shift-add-3 passes
    logic locate;   // latch the index of the leading digit
    logic advance;  // move to the next lower digit
    logic sel_sign; // drive '-' on the output word
  } itoa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic neg;
    logic conv_done;
    logic digit_last;
  } itoa_sts_t;

endpackage

@@ design/itoa_in_if.sv @@
// Input channel of the signed integer to decimal ASCII unit.
// Carries valid, ready and the signed word; uses itoa_pkg.
interface itoa_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [itoa_pkg::VALUE_W-1:0] value;

  modport source(output valid, output value, input ready);
  modport sink(input valid, input value, output ready);
endinterface

@@ design/itoa_out_if.sv @@
// Output channel of the signed integer to decimal ASCII unit.
// Carries valid, ready, one character and its last flag; uses itoa_pkg.
interface itoa_out_if;
  logic                        valid;
  logic                        ready;
  logic [itoa_pkg::CHAR_W-1:0] char_code;
  logic                        last_char;

  modport source(output valid, output char_code, output last_char, input ready);
  modport sink(input valid, input char_code, input last_char, output ready);
endinterface

@@ design/signed_int_to_decimal_ascii_unit.sv @@
// Top level of the signed integer to decimal ASCII unit.
// Depends on itoa_pkg, itoa_in_if, itoa_out_if, itoa_ctrl and itoa_datapath.
//
//   channel | modport | word
//   --------+---------+------------------------------------------
//   din     | sink    | value: signed 32-bit integer
//   dout    | source  | char_code: '-' or '0'..'9', last_char
//
// One word is converted at a time. A word is accepted in idle, converted in the
// 4-bit-per-cycle shift-add-3 converter, searched for its leading digit, then sent
// one character per cycle while dout is ready (sign plus 1..10 digits at 32 bits).
// Synchronous active-high reset returns the controller to idle; no clearing pass.
// A stall on dout holds the current character; din is not ready until the last one goes.
module signed_int_to_decimal_ascii_unit #(
  parameter int WORD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  itoa_in_if.sink    din,
  itoa_out_if.source dout
);

  itoa_pkg::itoa_cmd_t cmd;
  itoa_pkg::itoa_sts_t sts;

  itoa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  itoa_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .value     (din.value),
    .cmd       (cmd),
    .sts       (sts),
    .char_code (dout.char_code),
    .last_char (dout.last_char)
  );

endmodule

@@ design/itoa_datapath.sv @@
// Datapath: magnitude, shift-add-3 binary to BCD converter, leading digit
// search and character select. Driven by itoa_ctrl through itoa_pkg types.
module itoa_datapath #(
  parameter int WORD_BITS = 32
) (
  input  logic                                clk,
  input  logic signed [itoa_pkg::VALUE_W-1:0] value,
  input  itoa_pkg::itoa_cmd_t                 cmd,
  output itoa_pkg::itoa_sts_t                 sts,
  output logic [itoa_pkg::CHAR_W-1:0]         char_code,
  output logic                                last_char
);

  localparam int BITS_PER_CYC = 4;
  localparam int CONV_CYC     = (WORD_BITS + BITS_PER_CYC - 1) / BITS_PER_CYC;
  localparam int MAG_W        = CONV_CYC * BITS_PER_CYC;
  localparam int NDIG         = (WORD_BITS * 30103) / 100000 + 1;
  localparam int DIG_IDX_W    = $clog2(NDIG);
  localparam int CNT_W        = $clog2(CONV_CYC);
  localparam int EXT_W        = (WORD_BITS > itoa_pkg::VALUE_W) ? WORD_BITS : itoa_pkg::VALUE_W;

  logic [EXT_W-1:0]            value_ext;
  logic [WORD_BITS-1:0]        word;
  logic                        word_neg;
  logic [WORD_BITS-1:0]        word_mag;

  logic                        neg;
  logic [NDIG-1:0][3:0]        bcd;
  logic [MAG_W-1:0]            bin;
  logic [CNT_W-1:0]            conv_cnt;
  logic [DIG_IDX_W-1:0]        dig_idx;

  logic [NDIG-1:0][3:0]        bcd_next;
  logic [MAG_W-1:0]            bin_next;
  logic [DIG_IDX_W-1:0]        lead_idx;

  // Take the low WORD_BITS bits; wider words see zeros above the port
  assign value_ext = EXT_W'($unsigned(value));
  assign word      = value_ext[WORD_BITS-1:0];
  assign word_neg  = word[WORD_BITS-1];
  assign word_mag  = word_neg ? (~word + WORD_BITS'(1)) : word;

  // Four shift-add-3 passes per cycle
  always_comb begin
    bcd_next = bcd;
    bin_next = bin;
    for (int s = 0; s < BITS_PER_CYC; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_next[d] >= 4'd5) begin
          bcd_next[d] = bcd_next[d] + 4'd3;
        end
      end
      {bcd_next, bin_next} = {bcd_next, bin_next} << 1;
    end
  end

  // Highest nonzero digit; zero leaves the units digit
  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i] != 4'd0) begin
        lead_idx = DIG_IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg      <= word_neg;
      bin      <= MAG_W'(word_mag);
      bcd      <= '0;
      conv_cnt <= '0;
    end else if (cmd.step) begin
      bin      <= bin_next;
      bcd      <= bcd_next;
      conv_cnt <= conv_cnt + CNT_W'(1);
    end
    if (cmd.locate) begin
      dig_idx <= lead_idx;
    end else if (cmd.advance) begin
      dig_idx <= dig_idx - DIG_IDX_W'(1);
    end
  end

  assign sts.neg        = neg;
  assign sts.conv_done  = (conv_cnt == CNT_W'(CONV_CYC - 1));
  assign sts.digit_last = (dig_idx == '0);

  assign char_code = cmd.sel_sign ? itoa_pkg::CHAR_MINUS
                                  : (itoa_pkg::CHAR_ZERO | {4'h0, bcd[dig_idx]});
  assign last_char = !cmd.sel_sign && (dig_idx == '0);

endmodule

@@ design/itoa_ctrl.sv @@
// Controller: sequences capture, conversion, leading digit search and the
// character stream. Talks to itoa_datapath through itoa_pkg command/status.
module itoa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  itoa_pkg::itoa_sts_t sts,
  output itoa_pkg::itoa_cmd_t cmd
);

  itoa_pkg::itoa_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itoa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      itoa_pkg::ST_IDLE: begin
        if (in_valid) state_next = itoa_pkg::ST_CONVERT;
      end
      itoa_pkg::ST_CONVERT: begin
        if (sts.conv_done) state_next = itoa_pkg::ST_LOCATE;
      end
      itoa_pkg::ST_LOCATE: begin
        state_next = sts.neg ? itoa_pkg::ST_SIGN : itoa_pkg::ST_DIGITS;
      end
      itoa_pkg::ST_SIGN: begin
        if (out_ready) state_next = itoa_pkg::ST_DIGITS;
      end
      itoa_pkg::ST_DIGITS: begin
        if (out_ready && sts.digit_last) state_next = itoa_pkg::ST_IDLE;
      end
      default: state_next = itoa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd          = '0;
    unique case (state)
      itoa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      itoa_pkg::ST_CONVERT: cmd.step = 1'b1;
      itoa_pkg::ST_LOCATE:  cmd.locate = 1'b1;
      itoa_pkg::ST_SIGN: begin
        out_valid    = 1'b1;
        cmd.sel_sign = 1'b1;
      end
      itoa_pkg::ST_DIGITS: begin
        out_valid   = 1'b1;
        // hold the index on the final digit
        cmd.advance = out_ready && !sts.digit_last;
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_conv_to_locate: assert property (@(posedge clk) disable iff (rst)
    (state == itoa_pkg::ST_CONVERT && sts.conv_done) |=> (state == itoa_pkg::ST_LOCATE))
    else $error("conversion did not hand over to leading digit search");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == itoa_pkg::ST_DIGITS && out_ready && sts.digit_last)
      |=> (state == itoa_pkg::ST_IDLE))
    else $error("final digit taken but controller not idle");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a word is still being sent");

  a_sign_only_neg: assert property (@(posedge clk) disable iff (rst)
    (state == itoa_pkg::ST_SIGN) |-> sts.neg)
    else $error("minus sign sent for a non-negative word");
`endif

endmodule
